/* rtl/core/ptg_pkg.sv */
`default_nettype none

package ptg_pkg;

  localparam int OP_W       = 2;
  localparam int CHAN_W     = 3;
  localparam int LEVEL_W    = 11;
  localparam int TIME_W     = 16;
  localparam int HITS_W     = 8;
  localparam int COUNT_W    = 16;
  localparam int MASK_W     = 8;
  localparam int STEP_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Depth of the command queue and of the result queue
  localparam int QUEUE_DEPTH = 2;

  // Opcodes of an input item
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TROUGH_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_WINDOW_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUIRED_HITS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_STEP_MS     = 3'd4;

  // Reset values of the configuration registers
  localparam logic [LEVEL_W-1:0] RST_PEAK_THRESHOLD   = 11'd819;
  localparam logic [LEVEL_W-1:0] RST_TROUGH_THRESHOLD = 11'd205;
  localparam logic [TIME_W-1:0]  RST_PEAK_WINDOW_MS   = 16'd500;
  localparam logic [HITS_W-1:0]  RST_REQUIRED_HITS    = 8'd3;
  localparam logic [STEP_W-1:0]  RST_TICK_STEP_MS     = 8'd16;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [CHAN_W-1:0]  channel;
    logic [LEVEL_W-1:0] level;
  } item_t;

  typedef struct packed {
    logic               fired;
    logic [COUNT_W-1:0] completed_count;
    logic [HITS_W-1:0]  pending_hits;
    logic [MASK_W-1:0]  armed_mask;
    logic [TIME_W-1:0]  elapsed_ms;
  } result_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] peak_threshold;
    logic [LEVEL_W-1:0] trough_threshold;
    logic [TIME_W-1:0]  peak_window_ms;
    logic [HITS_W-1:0]  required_hits;
    logic [STEP_W-1:0]  tick_step_ms;
  } cfg_t;

  // Classified item handed from the front end to the back end
  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic              chan_ok;
    logic [CHAN_W-1:0] channel;
    logic              above_peak;
    logic              below_trough;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/core/ptg_queue.sv */
`default_nettype none

module ptg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ptg_front.sv */
`default_nettype none

module ptg_front #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic           push,
  output logic           full,
  input  ptg_pkg::item_t item,
  input  ptg_pkg::cfg_t  cfg,
  output ptg_pkg::cmd_t  cmd,
  output logic           cmd_push,
  input  logic           cmd_full
);

  import ptg_pkg::*;

  // Accept while the command queue has room
  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full;

  // Classify: channel range and both level compares
  always_comb begin
    cmd.opcode       = item.opcode;
    cmd.channel      = item.channel;
    cmd.chan_ok      = (int'(item.channel) < NUM_CHANNELS);
    cmd.above_peak   = (item.level > cfg.peak_threshold);
    cmd.below_trough = (item.level < cfg.trough_threshold);
  end

endmodule

`default_nettype wire

/* rtl/core/ptg_back.sv */
`default_nettype none

module ptg_back #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  ptg_pkg::cfg_t    cfg,
  input  ptg_pkg::cmd_t    cmd,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output ptg_pkg::result_t res
);

  import ptg_pkg::*;

  localparam int ARM_W = (NUM_CHANNELS < MASK_W) ? NUM_CHANNELS : MASK_W;

  logic [ARM_W-1:0]   armed;
  logic [ARM_W-1:0]   armed_next;
  logic [TIME_W-1:0]  peak_timer;
  logic [TIME_W-1:0]  peak_timer_next;
  logic               timer_running;
  logic               timer_running_next;
  logic [HITS_W-1:0]  hit_tally;
  logic [HITS_W-1:0]  hit_tally_next;
  logic [COUNT_W-1:0] gesture_tally;
  logic [COUNT_W-1:0] gesture_tally_next;
  logic               fired_flag;
  logic               fired_flag_next;

  logic [ARM_W-1:0]   sel;
  logic               armed_cur;
  logic               arm_now;
  logic               still_armed;
  logic               hit;
  logic [TIME_W-1:0]  timer_eff;
  logic [TIME_W:0]    tick_sum;
  logic [HITS_W-1:0]  hit_inc;

  assign cmd_pop  = cmd_valid && !res_full;
  assign res_push = cmd_pop;

  always_comb begin
    for (int c = 0; c < ARM_W; c++) begin
      sel[c] = cmd.chan_ok && (cmd.channel == CHAN_W'(c));
    end
    armed_cur = |(armed & sel);
    tick_sum  = {1'b0, peak_timer} + {{(TIME_W + 1 - STEP_W){1'b0}}, cfg.tick_step_ms};
    hit_inc   = hit_tally + 1'b1;

    armed_next         = armed;
    peak_timer_next    = peak_timer;
    timer_running_next = timer_running;
    hit_tally_next     = hit_tally;
    gesture_tally_next = gesture_tally;
    fired_flag_next    = fired_flag;
    arm_now            = 1'b0;
    still_armed        = 1'b0;
    hit                = 1'b0;
    timer_eff          = peak_timer;

    case (cmd.opcode)
      OP_SAMPLE: begin
        if (cmd.chan_ok) begin
          arm_now     = cmd.above_peak && !armed_cur;
          timer_eff   = arm_now ? '0 : peak_timer;
          still_armed = armed_cur || arm_now;
          if (arm_now) begin
            peak_timer_next    = '0;
            timer_running_next = 1'b1;
          end
          // Trough check first, then timeout drop
          if (still_armed && cmd.below_trough) begin
            hit         = (timer_eff < cfg.peak_window_ms);
            still_armed = 1'b0;
          end else if (still_armed && (timer_eff > cfg.peak_window_ms)) begin
            still_armed = 1'b0;
          end
          armed_next = still_armed ? (armed | sel) : (armed & ~sel);
          if (hit) begin
            if (hit_inc >= cfg.required_hits) begin
              if (gesture_tally != '1) begin
                gesture_tally_next = gesture_tally + 1'b1;
              end
              fired_flag_next = 1'b1;
              hit_tally_next  = '0;
            end else begin
              hit_tally_next = hit_inc;
            end
          end
        end
      end
      OP_TICK: begin
        if (timer_running) begin
          peak_timer_next = tick_sum[TIME_W] ? '1 : tick_sum[TIME_W-1:0];
        end
      end
      OP_CLEAR: begin
        armed_next         = '0;
        timer_running_next = 1'b0;
        hit_tally_next     = '0;
        gesture_tally_next = '0;
        fired_flag_next    = 1'b0;
      end
      default: begin
      end
    endcase

    res                        = '0;
    res.fired                  = fired_flag_next;
    res.completed_count        = gesture_tally_next;
    res.pending_hits           = hit_tally_next;
    res.armed_mask[ARM_W-1:0]  = armed_next;
    res.elapsed_ms             = peak_timer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed         <= '0;
      peak_timer    <= '0;
      timer_running <= 1'b0;
      hit_tally     <= '0;
      gesture_tally <= '0;
      fired_flag    <= 1'b0;
    end else if (cmd_pop) begin
      armed         <= armed_next;
      peak_timer    <= peak_timer_next;
      timer_running <= timer_running_next;
      hit_tally     <= hit_tally_next;
      gesture_tally <= gesture_tally_next;
      fired_flag    <= fired_flag_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/peak_trough_hit_gesture_counter.sv */
`default_nettype none

// Channel   Handshake                 Payload
// item      push / full               item   (opcode, channel, level)
// result    pop / empty               result (fired, completed_count, pending_hits,
//                                             armed_mask, elapsed_ms)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle sustained while the command queue has room. The command
// queue registers an item at the edge that takes it; the back end then updates
// the state and writes the result into the result queue, and the result sits on
// the result ports once the result queue holds it.
// rst is synchronous: it empties both queues, clears the detector state and
// loads the register defaults. No clearing pass follows.
// The front end stalls only on a full command queue, the back end only on a
// full result queue; cfg_ready stays high.

module peak_trough_hit_gesture_counter #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  ptg_pkg::item_t                       item,
  output logic                                 empty,
  input  logic                                 pop,
  output ptg_pkg::result_t                     result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ptg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ptg_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import ptg_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd_in;
  cmd_t    cmd_out;
  logic    cmd_push;
  logic    cmd_full;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    res_push;
  logic    res_full;
  result_t res_in;

  // Configuration registers; always ready. Write them only while idle; the block does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.peak_threshold   <= RST_PEAK_THRESHOLD;
      cfg.trough_threshold <= RST_TROUGH_THRESHOLD;
      cfg.peak_window_ms   <= RST_PEAK_WINDOW_MS;
      cfg.required_hits    <= RST_REQUIRED_HITS;
      cfg.tick_step_ms     <= RST_TICK_STEP_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PEAK_THRESHOLD:   cfg.peak_threshold   <= cfg_data[LEVEL_W-1:0];
        CFG_TROUGH_THRESHOLD: cfg.trough_threshold <= cfg_data[LEVEL_W-1:0];
        CFG_PEAK_WINDOW_MS:   cfg.peak_window_ms   <= cfg_data[TIME_W-1:0];
        CFG_REQUIRED_HITS:    cfg.required_hits    <= cfg_data[HITS_W-1:0];
        CFG_TICK_STEP_MS:     cfg.tick_step_ms     <= cfg_data[STEP_W-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Front end: take the item, check the channel, compare the level
  ptg_front #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .push     (push),
    .full     (full),
    .item     (item),
    .cfg      (cfg),
    .cmd      (cmd_in),
    .cmd_push (cmd_push),
    .cmd_full (cmd_full)
  );

  // Command queue decouples intake from the state update
  ptg_queue #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Back end: update the detector state and form one result per command
  ptg_back #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd_out),
    .cmd_valid (!cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue: hold finished results until the consumer pops them
  ptg_queue #(
    .WIDTH($bits(result_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

`default_nettype wire

/* rtl/core/ptg_checker.sv */
`default_nettype none

module ptg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           push,
  input logic                           full,
  input ptg_pkg::item_t                 item,
  input logic                           empty,
  input logic                           pop,
  input ptg_pkg::result_t               result,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [ptg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [ptg_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result waiting after reset");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("stalled result changed");

  // A transaction taken by an empty block shows a result once it has passed the command queue and the result queue
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (push && !full && empty) |-> ##2 !empty)
    else $error("result missing after accepted item");

  // A counted gesture always comes with the fired flag
  a_count_fired: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.completed_count != '0)) |-> result.fired)
    else $error("completed count without fired flag");

endmodule

bind peak_trough_hit_gesture_counter ptg_checker u_checker (.*);

`default_nettype wire
